FILE: design/ffcc_pkg.sv
// ffcc_pkg: shared types, constants and helper functions for the force-free
// current cell update pipeline
// no dependencies
package ffcc_pkg;

  // fixed point layout
  localparam int FRAC = 24;
  localparam int DW   = 32;

  // divider over |B|^2: 112-bit numerator, 64-bit divisor, 64 quotient bits
  localparam int D1_NW = 112;
  localparam int D1_QW = 64;
  localparam int D1_K  = 2;
  localparam int D1_NS = D1_QW / D1_K;

  // divider over time step: 90-bit numerator, 31-bit divisor, 44 quotient bits
  localparam int D2_NW = 90;
  localparam int D2_QW = 44;
  localparam int D2_DW = 31;
  localparam int D2_K  = 4;
  localparam int D2_NS = D2_QW / D2_K;

  // square root of a 48-bit fraction, 24 result bits
  localparam int SQ_W  = 2 * FRAC;
  localparam int SQ_RW = FRAC;
  localparam int SQ_K  = 2;
  localparam int SQ_NS = SQ_RW / SQ_K;

  // magnitude cap applied before a saturating add
  localparam logic [40:0] CAP40    = 41'd1 << 40;
  localparam logic [24:0] DISS_ONE = 25'd1 << FRAC;

  // configuration register indexes
  localparam logic [0:0] REG_TIME_STEP = 1'b0;
  localparam logic [0:0] REG_EPSILON   = 1'b1;

  typedef enum logic [1:0] {
    OP_DRIFT    = 2'd0,
    OP_PARALLEL = 2'd1,
    OP_LIMIT    = 2'd2,
    OP_PASS     = 2'd3
  } op_t;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;

  // per-item context carried down the pipeline
  typedef struct packed {
    op_t                op;
    logic               sgn;
    logic               lim;
    logic signed [31:0] curr;
    logic signed [31:0] ecell;
    logic signed [31:0] pend;
    logic [62:0]        qc;
    logic [62:0]        pp_lo;
    logic [61:0]        pp_hi;
    logic [40:0]        dqc;
    logic [31:0]        emag;
  } ctx_t;

  // finished transaction
  typedef struct packed {
    logic signed [31:0] cur;
    logic signed [31:0] ecell;
    logic signed [31:0] pend;
    logic               sat;
  } res_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // base +/- mag, clipped to 32 bits; msb of the result is the clip flag
  function automatic logic [32:0] add_sat(input logic signed [31:0] base,
                                          input logic neg,
                                          input logic [40:0] mag);
    logic signed [42:0] m;
    logic signed [42:0] s;
    m = signed'({2'b00, mag});
    s = neg ? (43'(base) - m) : (43'(base) + m);
    if (s > 43'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (s < -43'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, s[31:0]};
  endfunction

endpackage

FILE: design/force_free_current_cell_update.sv
// force_free_current_cell_update: top level of the force-free current kernel
// depends on ffcc_pkg, ffcc_div_b, ffcc_sqrt, ffcc_div_t
//
// Takes one cell component per clock unless stalled and returns one result per
// transaction, in order, through five front stages (products, sums, sign/magnitude,
// partial products, numerator), a 33-stage divider by |B|^2+eps (|E|^2+eps for the
// limit op), one stage of time-step products, a 13-stage square root, one stage of
// dissipation products, a 12-stage divider by the time step and the output register.
// Every stage is a register stage that accepts a new transaction each cycle unless
// stalled; an output register plus one skid entry let the input keep moving while a
// result waits. time_step and epsilon must only be written while the block is empty.
module force_free_current_cell_update import ffcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [1:0]         axis,
  input  logic signed [31:0] charge_interp,
  input  logic signed [31:0] efield_x,
  input  logic signed [31:0] efield_y,
  input  logic signed [31:0] efield_z,
  input  logic signed [31:0] bfield_x,
  input  logic signed [31:0] bfield_y,
  input  logic signed [31:0] bfield_z,
  input  logic signed [31:0] e_cell,
  input  logic signed [31:0] e_pending,
  input  logic signed [31:0] current_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] current_out,
  output logic signed [31:0] e_cell_out,
  output logic signed [31:0] e_pending_out,
  output logic               saturated
);

  logic [30:0] time_step;
  logic [15:0] epsilon;
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 31'd7549747;
      epsilon   <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIME_STEP: time_step <= cfg_data;
        REG_EPSILON:   epsilon   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage 1: all 32x32 products
  logic signed [31:0] c1a, c1b, c2a, c2b, bax_in;
  ctx_t               ctx_in;

  always_comb begin
    case (axis)
      AX_X: begin
        c1a = efield_y; c1b = bfield_z; c2a = bfield_y; c2b = efield_z;
        bax_in = bfield_x;
      end
      AX_Y: begin
        c1a = efield_z; c1b = bfield_x; c2a = efield_x; c2b = bfield_z;
        bax_in = bfield_y;
      end
      default: begin
        c1a = efield_x; c1b = bfield_y; c2a = bfield_x; c2b = efield_y;
        bax_in = bfield_z;
      end
    endcase
    ctx_in       = '0;
    ctx_in.op    = op_t'(op);
    ctx_in.curr  = current_in;
    ctx_in.ecell = e_cell;
    ctx_in.pend  = e_pending;
  end

  logic               s1_v;
  logic signed [63:0] s1_bb [3];
  logic signed [63:0] s1_ee [3];
  logic signed [63:0] s1_eb [3];
  logic signed [63:0] s1_c1, s1_c2;
  logic signed [31:0] s1_rho, s1_bax;
  ctx_t               s1_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
    if (en) begin
      s1_bb[0] <= bfield_x * bfield_x;
      s1_bb[1] <= bfield_y * bfield_y;
      s1_bb[2] <= bfield_z * bfield_z;
      s1_ee[0] <= efield_x * efield_x;
      s1_ee[1] <= efield_y * efield_y;
      s1_ee[2] <= efield_z * efield_z;
      s1_eb[0] <= efield_x * bfield_x;
      s1_eb[1] <= efield_y * bfield_y;
      s1_eb[2] <= efield_z * bfield_z;
      s1_c1    <= c1a * c1b;
      s1_c2    <= c2a * c2b;
      s1_rho   <= charge_interp;
      s1_bax   <= bax_in;
      s1_ctx   <= ctx_in;
    end
  end

  // stage 2: squared magnitudes, split dot product, cross difference
  logic               s2_v;
  logic [63:0]        s2_bsq, s2_esq, s2_pos, s2_neg;
  logic signed [64:0] s2_cd;
  logic signed [31:0] s2_rho, s2_bax;
  ctx_t               s2_ctx;
  logic [63:0]        eps_sh;

  assign eps_sh = 64'(epsilon) << FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
    if (en) begin
      s2_bsq <= 64'(s1_bb[0]) + 64'(s1_bb[1]) + 64'(s1_bb[2]) + eps_sh;
      s2_esq <= 64'(s1_ee[0]) + 64'(s1_ee[1]) + 64'(s1_ee[2]) + eps_sh;
      s2_pos <= (s1_eb[0][63] ? 64'd0 : 64'(s1_eb[0]))
              + (s1_eb[1][63] ? 64'd0 : 64'(s1_eb[1]))
              + (s1_eb[2][63] ? 64'd0 : 64'(s1_eb[2]));
      s2_neg <= (s1_eb[0][63] ? 64'(-s1_eb[0]) : 64'd0)
              + (s1_eb[1][63] ? 64'(-s1_eb[1]) : 64'd0)
              + (s1_eb[2][63] ? 64'(-s1_eb[2]) : 64'd0);
      s2_cd  <= 65'(s1_c1) - 65'(s1_c2);
      s2_rho <= s1_rho;
      s2_bax <= s1_bax;
      s2_ctx <= s1_ctx;
    end
  end

  // stage 3: sign and magnitude of the numerator factors
  logic        s3_v;
  logic [63:0] s3_m, s3_bsq, s3_esq;
  logic [31:0] s3_a;
  ctx_t        s3_ctx;
  logic        dneg, cneg;
  logic [63:0] dm, cm;
  logic [64:0] cd_neg;
  ctx_t        ctx3;

  always_comb begin
    dneg   = s2_neg > s2_pos;
    dm     = dneg ? (s2_neg - s2_pos) : (s2_pos - s2_neg);
    cneg   = s2_cd[64];
    cd_neg = ~s2_cd + 65'd1;
    cm     = cneg ? cd_neg[63:0] : s2_cd[63:0];
    ctx3     = s2_ctx;
    ctx3.lim = s2_esq > s2_bsq;
    ctx3.sgn = (s2_ctx.op == OP_DRIFT) ? (cneg ^ s2_rho[31]) : (dneg ^ s2_bax[31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
    if (en) begin
      s3_m   <= (s2_ctx.op == OP_DRIFT) ? cm : dm;
      s3_a   <= (s2_ctx.op == OP_DRIFT) ? mag32(s2_rho) : mag32(s2_bax);
      s3_bsq <= s2_bsq;
      s3_esq <= s2_esq;
      s3_ctx <= ctx3;
    end
  end

  // stage 4: 32x64 product as two 32x32 partial products
  logic        s4_v;
  logic [63:0] s4_pl, s4_ph, s4_bsq, s4_esq;
  ctx_t        s4_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
    if (en) begin
      s4_pl  <= 64'(s3_a) * 64'(s3_m[31:0]);
      s4_ph  <= 64'(s3_a) * 64'(s3_m[63:32]);
      s4_bsq <= s3_bsq;
      s4_esq <= s3_esq;
      s4_ctx <= s3_ctx;
    end
  end

  // stage 5: divider operands; the limit op divides |B|^2 << 48 by |E|^2
  logic             s5_v;
  logic [D1_NW-1:0] s5_n;
  logic [63:0]      s5_d;
  ctx_t             s5_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
    if (en) begin
      if (s4_ctx.op == OP_LIMIT) begin
        s5_n <= {s4_bsq, 48'b0};
        s5_d <= s4_esq;
      end else begin
        s5_n <= D1_NW'(s4_pl) + (D1_NW'(s4_ph) << 32);
        s5_d <= s4_bsq;
      end
      s5_ctx <= s4_ctx;
    end
  end

  logic        d1_v;
  logic [62:0] d1_q;
  ctx_t        d1_ctx;

  ffcc_div_b u_div_b (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (s5_v),
    .num     (s5_n),
    .den     (s5_d),
    .ctx_in  (s5_ctx),
    .out_v   (d1_v),
    .quo     (d1_q),
    .ctx_out (d1_ctx)
  );

  // stage 6: keep the quotient and form time_step * quotient partial products
  logic s6_v;
  ctx_t s6_ctx;
  ctx_t ctx6;

  always_comb begin
    ctx6       = d1_ctx;
    ctx6.qc    = d1_q;
    ctx6.pp_lo = 63'(time_step) * 63'(d1_q[31:0]);
    ctx6.pp_hi = 62'(time_step) * 62'(d1_q[62:32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= d1_v;
    end
    if (en) begin
      s6_ctx <= ctx6;
    end
  end

  logic              sq_v;
  logic [SQ_RW-1:0]  sq_r;
  ctx_t              sq_ctx;

  ffcc_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (s6_v),
    .x       (s6_ctx.qc[SQ_W-1:0]),
    .ctx_in  (s6_ctx),
    .out_v   (sq_v),
    .root    (sq_r),
    .ctx_out (sq_ctx)
  );

  // stage 7: dissipation products, drift pending step, second divider numerator
  logic             s7_v;
  logic [D2_NW-1:0] s7_n;
  ctx_t             s7_ctx;
  logic [24:0]      diss;
  logic [56:0]      md, mp;
  logic [93:0]      dq_sum;
  logic [69:0]      dq;
  ctx_t             ctx7;

  always_comb begin
    diss   = (sq_ctx.op == OP_LIMIT && sq_ctx.lim) ? {1'b0, sq_r} : DISS_ONE;
    md     = 57'(DISS_ONE - diss) * 57'(mag32(sq_ctx.ecell));
    mp     = 57'(diss) * 57'(mag32(sq_ctx.pend));
    dq_sum = 94'(sq_ctx.pp_lo) + (94'(sq_ctx.pp_hi) << 32);
    dq     = dq_sum[93:FRAC];
    ctx7      = sq_ctx;
    ctx7.dqc  = (dq > 70'(CAP40)) ? CAP40 : dq[40:0];
    ctx7.emag = mp[55:FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= sq_v;
    end
    if (en) begin
      s7_n   <= (sq_ctx.op == OP_PARALLEL) ? {3'b0, sq_ctx.qc, 24'b0} : D2_NW'(md);
      s7_ctx <= ctx7;
    end
  end

  logic        d2_v;
  logic [40:0] d2_q;
  ctx_t        d2_ctx;

  ffcc_div_t u_div_t (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (s7_v),
    .num     (s7_n),
    .den     (time_step),
    .ctx_in  (s7_ctx),
    .out_v   (d2_v),
    .quo     (d2_q),
    .ctx_out (d2_ctx)
  );

  // final saturating adds per op
  res_t        fin;
  logic [40:0] q40;
  logic [32:0] r1, r2;

  always_comb begin
    q40 = (d2_ctx.qc > 63'(CAP40)) ? CAP40 : d2_ctx.qc[40:0];
    r1  = '0;
    r2  = '0;
    fin.cur   = d2_ctx.curr;
    fin.ecell = d2_ctx.ecell;
    fin.pend  = d2_ctx.pend;
    fin.sat   = 1'b0;
    case (d2_ctx.op)
      OP_DRIFT: begin
        r1 = add_sat(32'sd0, d2_ctx.sgn, q40);
        r2 = add_sat(d2_ctx.pend, !d2_ctx.sgn, d2_ctx.dqc);
        fin.cur  = r1[31:0];
        fin.pend = r2[31:0];
        fin.sat  = r1[32] | r2[32];
      end
      OP_PARALLEL: begin
        r1 = add_sat(d2_ctx.curr, d2_ctx.sgn, d2_q);
        r2 = add_sat(d2_ctx.ecell, !d2_ctx.sgn, q40);
        fin.cur  = r1[31:0];
        fin.pend = r2[31:0];
        fin.sat  = r1[32] | r2[32];
      end
      OP_LIMIT: begin
        r1 = add_sat(d2_ctx.curr, d2_ctx.ecell[31], d2_q);
        r2 = add_sat(32'sd0, d2_ctx.pend[31], {9'b0, d2_ctx.emag});
        fin.cur   = r1[31:0];
        fin.ecell = r2[31:0];
        fin.sat   = r1[32] | r2[32];
      end
      default: ;
    endcase
  end

  // output register with one skid entry
  res_t out_q, skid_q;
  logic out_v, skid_v, push;

  assign en       = !skid_v;
  assign in_ready = en;
  assign push     = en && d2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (!out_v || out_ready) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (out_ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v && out_ready) begin
      out_q <= skid_q;
    end else if (!skid_v && push) begin
      if (!out_v || out_ready) begin
        out_q <= fin;
      end else begin
        skid_q <= fin;
      end
    end
  end

  assign out_valid     = out_v;
  assign current_out   = out_q.cur;
  assign e_cell_out    = out_q.ecell;
  assign e_pending_out = out_q.pend;
  assign saturated     = out_q.sat;

endmodule

FILE: design/ffcc_div_b.sv
// ffcc_div_b: pipelined restoring divider by the 64-bit squared magnitude,
// two quotient bits per stage, result capped to 63 bits
// depends on ffcc_pkg
module ffcc_div_b import ffcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_v,
  input  logic [D1_NW-1:0]   num,
  input  logic [63:0]        den,
  input  ctx_t               ctx_in,
  output logic               out_v,
  output logic [62:0]        quo,
  output ctx_t               ctx_out
);

  logic              v_q    [D1_NS+1];
  logic [63:0]       rem_q  [D1_NS+1];
  logic [63:0]       wq_q   [D1_NS+1];
  logic [63:0]       den_q  [D1_NS+1];
  logic              ovf_q  [D1_NS+1];
  logic              zero_q [D1_NS+1];
  ctx_t              ctx_q  [D1_NS+1];

  logic              v_n    [D1_NS+1];
  logic [63:0]       rem_n  [D1_NS+1];
  logic [63:0]       wq_n   [D1_NS+1];
  logic [63:0]       den_n  [D1_NS+1];
  logic              ovf_n  [D1_NS+1];
  logic              zero_n [D1_NS+1];
  ctx_t              ctx_n  [D1_NS+1];

  logic [63:0]       r_c;
  logic [63:0]       x_c;
  logic [64:0]       t_c;

  // entry stage and shift-subtract steps
  always_comb begin
    v_n[0]    = in_v;
    rem_n[0]  = {16'b0, num[D1_NW-1:D1_QW]};
    wq_n[0]   = num[D1_QW-1:0];
    den_n[0]  = den;
    zero_n[0] = (num == '0);
    ovf_n[0]  = (den == '0) ? (num != '0) : ({16'b0, num[D1_NW-1:D1_QW]} >= den);
    ctx_n[0]  = ctx_in;
    r_c = '0;
    x_c = '0;
    t_c = '0;
    for (int s = 0; s < D1_NS; s++) begin
      r_c = rem_q[s];
      x_c = wq_q[s];
      for (int k = 0; k < D1_K; k++) begin
        t_c = {r_c, x_c[63]};
        x_c = {x_c[62:0], 1'b0};
        if (t_c >= {1'b0, den_q[s]}) begin
          t_c = t_c - {1'b0, den_q[s]};
          x_c[0] = 1'b1;
        end
        r_c = t_c[63:0];
      end
      v_n[s+1]    = v_q[s];
      rem_n[s+1]  = r_c;
      wq_n[s+1]   = x_c;
      den_n[s+1]  = den_q[s];
      ovf_n[s+1]  = ovf_q[s];
      zero_n[s+1] = zero_q[s];
      ctx_n[s+1]  = ctx_q[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '{default: 1'b0};
    end else if (en) begin
      v_q <= v_n;
    end
    if (en) begin
      rem_q  <= rem_n;
      wq_q   <= wq_n;
      den_q  <= den_n;
      ovf_q  <= ovf_n;
      zero_q <= zero_n;
      ctx_q  <= ctx_n;
    end
  end

  // zero numerator gives zero, else cap the quotient to 63 bits
  // (zero divisor with nonzero numerator gives all ones)
  always_comb begin
    if (zero_q[D1_NS]) begin
      quo = '0;
    end else if (ovf_q[D1_NS] || wq_q[D1_NS][63]) begin
      quo = '1;
    end else begin
      quo = wq_q[D1_NS][62:0];
    end
  end

  assign out_v   = v_q[D1_NS];
  assign ctx_out = ctx_q[D1_NS];

endmodule

FILE: design/ffcc_sqrt.sv
// ffcc_sqrt: pipelined digit-by-digit integer square root of a 48-bit value,
// two result bits per stage
// depends on ffcc_pkg
module ffcc_sqrt import ffcc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  logic [SQ_W-1:0]  x,
  input  ctx_t             ctx_in,
  output logic             out_v,
  output logic [SQ_RW-1:0] root,
  output ctx_t             ctx_out
);

  logic             v_q   [SQ_NS+1];
  logic [SQ_W-1:0]  op_q  [SQ_NS+1];
  logic [SQ_W-1:0]  res_q [SQ_NS+1];
  ctx_t             ctx_q [SQ_NS+1];

  logic             v_n   [SQ_NS+1];
  logic [SQ_W-1:0]  op_n  [SQ_NS+1];
  logic [SQ_W-1:0]  res_n [SQ_NS+1];
  ctx_t             ctx_n [SQ_NS+1];

  logic [SQ_W-1:0]  o_c;
  logic [SQ_W-1:0]  r_c;
  logic [SQ_W-1:0]  bit_c;
  logic [SQ_W:0]    trial_c;

  // each step tries the next root bit against the running remainder
  always_comb begin
    v_n[0]   = in_v;
    op_n[0]  = x;
    res_n[0] = '0;
    ctx_n[0] = ctx_in;
    o_c = '0;
    r_c = '0;
    bit_c = '0;
    trial_c = '0;
    for (int s = 0; s < SQ_NS; s++) begin
      o_c = op_q[s];
      r_c = res_q[s];
      for (int k = 0; k < SQ_K; k++) begin
        bit_c   = SQ_W'(1) << (SQ_W - 2 - 2 * (s * SQ_K + k));
        trial_c = {1'b0, r_c} + {1'b0, bit_c};
        if ({1'b0, o_c} >= trial_c) begin
          o_c = o_c - trial_c[SQ_W-1:0];
          r_c = (r_c >> 1) + bit_c;
        end else begin
          r_c = r_c >> 1;
        end
      end
      v_n[s+1]   = v_q[s];
      op_n[s+1]  = o_c;
      res_n[s+1] = r_c;
      ctx_n[s+1] = ctx_q[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '{default: 1'b0};
    end else if (en) begin
      v_q <= v_n;
    end
    if (en) begin
      op_q  <= op_n;
      res_q <= res_n;
      ctx_q <= ctx_n;
    end
  end

  assign out_v   = v_q[SQ_NS];
  assign root    = res_q[SQ_NS][SQ_RW-1:0];
  assign ctx_out = ctx_q[SQ_NS];

endmodule

FILE: design/ffcc_div_t.sv
// ffcc_div_t: pipelined restoring divider by the 31-bit time step,
// four quotient bits per stage, result capped to 2^40
// depends on ffcc_pkg
module ffcc_div_t import ffcc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  logic [D2_NW-1:0]  num,
  input  logic [D2_DW-1:0]  den,
  input  ctx_t              ctx_in,
  output logic              out_v,
  output logic [40:0]       quo,
  output ctx_t              ctx_out
);

  // user keeps den (time step register) still with items in flight; unchecked

  logic              v_q    [D2_NS+1];
  logic [D2_DW-1:0]  rem_q  [D2_NS+1];
  logic [D2_QW-1:0]  wq_q   [D2_NS+1];
  logic              ovf_q  [D2_NS+1];
  logic              zero_q [D2_NS+1];
  ctx_t              ctx_q  [D2_NS+1];

  logic              v_n    [D2_NS+1];
  logic [D2_DW-1:0]  rem_n  [D2_NS+1];
  logic [D2_QW-1:0]  wq_n   [D2_NS+1];
  logic              ovf_n  [D2_NS+1];
  logic              zero_n [D2_NS+1];
  ctx_t              ctx_n  [D2_NS+1];

  logic [D2_DW-1:0]  r_c;
  logic [D2_QW-1:0]  x_c;
  logic [D2_DW:0]    t_c;

  always_comb begin
    v_n[0]    = in_v;
    rem_n[0]  = num[D2_QW+D2_DW-1:D2_QW];
    wq_n[0]   = num[D2_QW-1:0];
    zero_n[0] = (num == '0);
    ovf_n[0]  = (den == '0) ? (num != '0) :
                (num[D2_NW-1:D2_QW] >= {{(D2_NW-D2_QW-D2_DW){1'b0}}, den});
    ctx_n[0]  = ctx_in;
    r_c = '0;
    x_c = '0;
    t_c = '0;
    for (int s = 0; s < D2_NS; s++) begin
      r_c = rem_q[s];
      x_c = wq_q[s];
      for (int k = 0; k < D2_K; k++) begin
        t_c = {r_c, x_c[D2_QW-1]};
        x_c = {x_c[D2_QW-2:0], 1'b0};
        if (t_c >= {1'b0, den}) begin
          t_c = t_c - {1'b0, den};
          x_c[0] = 1'b1;
        end
        r_c = t_c[D2_DW-1:0];
      end
      v_n[s+1]    = v_q[s];
      rem_n[s+1]  = r_c;
      wq_n[s+1]   = x_c;
      ovf_n[s+1]  = ovf_q[s];
      zero_n[s+1] = zero_q[s];
      ctx_n[s+1]  = ctx_q[s];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '{default: 1'b0};
    end else if (en) begin
      v_q <= v_n;
    end
    if (en) begin
      rem_q  <= rem_n;
      wq_q   <= wq_n;
      ovf_q  <= ovf_n;
      zero_q <= zero_n;
      ctx_q  <= ctx_n;
    end
  end

  // zero numerator gives zero, else cap at 2^40
  // (zero divisor with nonzero numerator also caps)
  always_comb begin
    if (zero_q[D2_NS]) begin
      quo = '0;
    end else if (ovf_q[D2_NS] || (wq_q[D2_NS] > D2_QW'(CAP40))) begin
      quo = CAP40;
    end else begin
      quo = wq_q[D2_NS][40:0];
    end
  end

  assign out_v   = v_q[D2_NS];
  assign ctx_out = ctx_q[D2_NS];

endmodule

FILE: dv/force_free_current_cell_update_tb.sv
// force_free_current_cell_update_tb: self-checking bench for the force-free current kernel
// depends on ffcc_pkg and force_free_current_cell_update
// predicts each transaction in fixed point, streams cells with bursts and output stalls
module force_free_current_cell_update_tb import ffcc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] AX_Z          = 2'd2;
  localparam logic [1:0] AX_ALIAS      = 2'd3;
  localparam logic [30:0] TS_RESET     = 31'd7549747;
  localparam logic [30:0] TS_MAX       = 31'h7fff_ffff;
  localparam logic signed [31:0] SMAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN  = 32'sh8000_0000;
  localparam logic signed [31:0] UNIT  = 32'sh0100_0000;
  localparam int IDLE_LIMIT            = 5000;
  localparam int DRAIN_CYCLES          = 100;

  typedef struct {
    logic [1:0]         op;
    logic [1:0]         axis;
    logic signed [31:0] rho, ex, ey, ez, bx, by, bz, ecell, pend, curr;
  } cell_t;

  typedef struct {
    logic signed [31:0] cur, ecell, pend;
    logic               sat;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = '0;
  logic [1:0] axis = '0;
  logic signed [31:0] charge_interp = '0, efield_x = '0, efield_y = '0, efield_z = '0;
  logic signed [31:0] bfield_x = '0, bfield_y = '0, bfield_z = '0;
  logic signed [31:0] e_cell = '0, e_pending = '0, current_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] current_out, e_cell_out, e_pending_out;
  logic saturated;

  // predictor copy of the registers
  logic [63:0] step_q;
  logic [63:0] eps_q;

  cell_t   pending_cells[$];
  update_t expected_updates[$];
  int      mismatches = 0;
  int      idle_cycles = 0;

  always #6 clk = ~clk;

  force_free_current_cell_update u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .op, .axis, .charge_interp,
    .efield_x, .efield_y, .efield_z, .bfield_x, .bfield_y, .bfield_z,
    .e_cell, .e_pending, .current_in,
    .out_valid, .out_ready, .current_out, .e_cell_out, .e_pending_out, .saturated
  );

  // ---------------------------------------------------------------- arithmetic

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // truncating quotient; a zero divisor gives zero or all ones
  function automatic logic [127:0] quot(logic [127:0] n, logic [63:0] d);
    if (d == 0) return (n == 0) ? 128'd0 : {128{1'b1}};
    return n / {64'd0, d};
  endfunction

  function automatic logic [127:0] cap_to(logic [127:0] x, logic [127:0] lim);
    return (x > lim) ? lim : x;
  endfunction

  function automatic logic [31:0] clip_add(longint base, bit neg, logic [127:0] mag,
                                           inout bit clip);
    longint m;
    longint s;
    m = longint'(cap_to(mag, 128'd1 << 40));
    s = neg ? base - m : base + m;
    if (s > 64'sd2147483647) begin
      clip = 1;
      return SMAX;
    end else if (s < -64'sd2147483648) begin
      clip = 1;
      return SMIN;
    end
    return s[31:0];
  endfunction

  function automatic logic [63:0] sum_squares(longint x, longint y, longint z);
    return 64'(x * x) + 64'(y * y) + 64'(z * z) + (eps_q << FRAC);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= x) r = t;
    end
    return r;
  endfunction

  // expected outputs for one cell
  function automatic update_t predict_cell_update(cell_t c);
    update_t u;
    bit clip, cneg, dneg, qneg;
    longint rho, ex, ey, ez, bx, by, bz, ec, pd, cu, bax, pa, pb;
    logic [63:0] bsq, esq, cm, pos, negs, dm, diss;
    logic [127:0] q, dq, q1, jc, lim63;
    longint p[3];
    rho = c.rho; ex = c.ex; ey = c.ey; ez = c.ez;
    bx = c.bx; by = c.by; bz = c.bz;
    ec = c.ecell; pd = c.pend; cu = c.curr;
    clip = 0;
    lim63 = {65'd0, {63{1'b1}}};
    u.cur = c.curr; u.ecell = c.ecell; u.pend = c.pend;
    bax = (c.axis == AX_X) ? bx : ((c.axis == AX_Y) ? by : bz);
    bsq = sum_squares(bx, by, bz);
    case (c.op)
      OP_DRIFT: begin
        if (c.axis == AX_X) begin
          pa = ey * bz; pb = by * ez;
        end else if (c.axis == AX_Y) begin
          pa = ez * bx; pb = ex * bz;
        end else begin
          pa = ex * by; pb = bx * ey;
        end
        cneg = pa < pb;
        cm = cneg ? 64'(pb) - 64'(pa) : 64'(pa) - 64'(pb);
        q = quot({64'd0, abs64(rho)} * {64'd0, cm}, bsq);
        cneg = cneg != (rho < 0);
        u.cur = clip_add(0, cneg, q, clip);
        dq = ({64'd0, step_q} * cap_to(q, lim63)) >> FRAC;
        u.pend = clip_add(pd, !cneg, dq, clip);
      end
      OP_PARALLEL: begin
        p[0] = ex * bx; p[1] = ey * by; p[2] = ez * bz;
        pos = 0; negs = 0;
        for (int i = 0; i < 3; i++) begin
          if (p[i] < 0) negs += abs64(p[i]);
          else pos += 64'(p[i]);
        end
        dneg = negs > pos;
        dm = dneg ? negs - pos : pos - negs;
        q1 = quot({64'd0, dm} * {64'd0, abs64(bax)}, bsq);
        qneg = dneg != (bax < 0);
        jc = quot(cap_to(q1, lim63) << FRAC, step_q);
        u.cur = clip_add(cu, qneg, jc, clip);
        u.pend = clip_add(ec, !qneg, q1, clip);
      end
      OP_LIMIT: begin
        esq = sum_squares(ex, ey, ez);
        diss = 64'd1 << FRAC;
        if (esq > bsq) diss = isqrt(({64'd0, bsq} << (2 * FRAC)) / {64'd0, esq});
        jc = quot({64'd0, (64'd1 << FRAC) - diss} * {64'd0, abs64(ec)}, step_q);
        u.cur = clip_add(cu, ec < 0, jc, clip);
        u.ecell = clip_add(0, pd < 0, ({64'd0, diss} * {64'd0, abs64(pd)}) >> FRAC, clip);
      end
      default: ;
    endcase
    u.sat = clip;
    return u;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_cell(op_t o, logic [1:0] a, logic signed [31:0] rho,
                          logic signed [31:0] ex, ey, ez, bx, by, bz,
                          logic signed [31:0] ec, pd, cu);
    cell_t c;
    c.op = o; c.axis = a; c.rho = rho;
    c.ex = ex; c.ey = ey; c.ez = ez; c.bx = bx; c.by = by; c.bz = bz;
    c.ecell = ec; c.pend = pd; c.curr = cu;
    pending_cells.push_back(c);
  endtask

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return SMAX;
          1: return SMIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  task automatic add_random_cells(int n);
    op_t o;
    for (int i = 0; i < n; i++) begin
      o = op_t'($urandom_range(0, 3));
      add_cell(o, 2'($urandom_range(0, 3)), rand_field(), rand_field(), rand_field(),
               rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
               rand_field(), rand_field());
    end
  endtask

  task automatic write_reg(logic [0:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_TIME_STEP) step_q = {33'd0, val};
    else eps_q = {48'd0, val[15:0]};
  endtask

  task automatic wait_empty();
    do @(posedge clk);
    while (pending_cells.size() != 0 || in_valid || expected_updates.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sender

  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    cell_t c;
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cells.size() != 0) begin
        c = pending_cells.pop_front();
        expected_updates.push_back(predict_cell_update(c));
        op <= c.op; axis <= c.axis; charge_interp <= c.rho;
        efield_x <= c.ex; efield_y <= c.ey; efield_z <= c.ez;
        bfield_x <= c.bx; bfield_y <= c.by; bfield_z <= c.bz;
        e_cell <= c.ecell; e_pending <= c.pend; current_in <= c.curr;
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_valid <= nv;
    end
  end

  // ---------------------------------------------------------------- receiver stall pattern

  int stall_phase = 0;
  int ready_pct = 100;

  always @(posedge clk) begin
    stall_phase++;
    if (stall_phase % 150 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
    end
    out_ready <= !rst && ($urandom_range(1, 100) <= ready_pct);
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  always @(posedge clk) begin
    update_t u;
    if (!rst && out_valid && out_ready) begin
      if (expected_updates.size() == 0) begin
        report_mismatch("unexpected transaction", current_out, 32'd0);
      end else begin
        u = expected_updates.pop_front();
        if (current_out !== u.cur) report_mismatch("current_out", current_out, u.cur);
        if (e_cell_out !== u.ecell) report_mismatch("e_cell_out", e_cell_out, u.ecell);
        if (e_pending_out !== u.pend)
          report_mismatch("e_pending_out", e_pending_out, u.pend);
        if (saturated !== u.sat)
          report_mismatch("saturated", {31'd0, saturated}, {31'd0, u.sat});
      end
    end
  end

  // watchdog over cycles with work waiting and no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_cells.size() == 0 && expected_updates.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    step_q = {33'd0, TS_RESET};
    eps_q = 64'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // default registers: extremes, every op and axis, limited and unlimited cells
    add_cell(OP_DRIFT, AX_X, SMAX, SMAX, SMAX, SMAX, SMAX, SMIN, SMAX, SMAX, SMAX, SMAX);
    add_cell(OP_DRIFT, AX_Y, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
    add_cell(OP_DRIFT, AX_Z, UNIT, UNIT, 0, 0, 0, UNIT, 0, 0, UNIT, 0);
    add_cell(OP_DRIFT, AX_ALIAS, -UNIT, 0, UNIT, 0, UNIT, 0, 0, 5, -7, 9);
    add_cell(OP_PARALLEL, AX_X, 0, UNIT, UNIT, 0, UNIT, 0, 0, UNIT, 0, 3);
    add_cell(OP_PARALLEL, AX_Y, 0, -UNIT, 2 * UNIT, 0, 0, -UNIT, 0, 7, 1, -3);
    add_cell(OP_PARALLEL, AX_Z, 0, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMAX, 0, SMIN);
    add_cell(OP_PARALLEL, AX_ALIAS, 0, 1, 1, SMIN, 1, 1, SMAX, SMIN, SMAX, SMAX);
    add_cell(OP_LIMIT, AX_X, 0, 4 * UNIT, 0, 0, UNIT, 0, 0, UNIT, -UNIT, 5);
    add_cell(OP_LIMIT, AX_Y, 0, 0, 0, 1, UNIT, UNIT, 0, -UNIT, UNIT, -5);
    add_cell(OP_LIMIT, AX_Z, 0, SMAX, SMIN, SMAX, 1, 0, 0, SMIN, SMIN, SMAX);
    add_cell(OP_LIMIT, AX_X, 0, SMIN, SMIN, SMIN, 0, 0, 0, SMAX, SMAX, SMIN);
    add_cell(OP_PASS, AX_X, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
    add_cell(OP_PASS, AX_ALIAS, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    add_random_cells(400);
    wait_empty();

    // smallest step and no guard: zero field makes a zero divisor
    write_reg(REG_TIME_STEP, 31'd1);
    write_reg(REG_EPSILON, 16'd0);
    add_cell(OP_DRIFT, AX_X, UNIT, UNIT, UNIT, UNIT, 0, 0, 0, 0, 3, 0);
    add_cell(OP_PARALLEL, AX_Y, 0, UNIT, UNIT, UNIT, 0, 0, 0, UNIT, 3, 4);
    add_cell(OP_LIMIT, AX_Z, 0, UNIT, 0, 0, 0, 0, 0, UNIT, UNIT, 1);
    add_cell(OP_LIMIT, AX_X, 0, 0, 0, 0, 0, 0, 0, UNIT, -UNIT, 1);
    add_cell(OP_PARALLEL, AX_X, 0, UNIT, 0, 0, UNIT, 0, 0, 0, 0, 0);
    add_random_cells(400);
    wait_empty();

    // largest step and guard
    write_reg(REG_TIME_STEP, TS_MAX);
    write_reg(REG_EPSILON, 16'hffff);
    add_random_cells(400);
    wait_empty();

    write_reg(REG_TIME_STEP, 31'($urandom_range(1, 32'h7fff_ffff)));
    write_reg(REG_EPSILON, 16'($urandom_range(0, 16'hffff)));
    add_random_cells(350);
    wait_empty();

    write_reg(REG_TIME_STEP, TS_RESET);
    write_reg(REG_EPSILON, 16'd1);
    add_random_cells(350);
    wait_empty();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
